[hdl/counted_bitmap_store_core_macros.svh]
// Assertion macros shared by the counted bitmap store RTL.
`ifndef COUNTED_BITMAP_STORE_CORE_MACROS_SVH
`define COUNTED_BITMAP_STORE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CBS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("counted bitmap store: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("counted bitmap store: next-cycle check failed");

`endif

[hdl/cbs_pkg.sv]
// Types, codes and helper functions for the counted bitmap store.
`timescale 1ns / 1ps

package cbs_pkg;

   localparam int COUNT_W = 13;
   localparam logic [COUNT_W-1:0] BITS_IN_USE_RESET = 13'd4096;

   localparam logic CSR_IDX_BITS_IN_USE = 1'b0;

   typedef enum logic [2:0] {
      OP_SET_BIT    = 3'd0,
      OP_CLEAR_BIT  = 3'd1,
      OP_TEST_BIT   = 3'd2,
      OP_WRITE_BYTE = 3'd3,
      OP_READ_BYTE  = 3'd4
   } op_type;

   typedef enum logic {
      ST_CLEAR = 1'b0,
      ST_RUN   = 1'b1
   } state_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [11:0] index;
      logic [7:0]  write_byte;
   } req_item_type;

   typedef struct packed {
      logic               bit_value;
      logic [7:0]         read_byte;
      logic [COUNT_W-1:0] ones_count;
      logic               range_error;
   } rsp_item_type;

   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, v[i]};
      end
      return n;
   endfunction

endpackage

[hdl/cbs_byte_ram.sv]
// Single-port-write, single-port-read byte memory with registered read data.
`timescale 1ns / 1ps

module cbs_byte_ram #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/counted_bitmap_store_core.sv]
// Top level of the counted bitmap store: decode, read-modify-write and register port.
//
//   channel   direction  handshake                      payload
//   request   in         start && !busy accepts a word  req_item (cbs_pkg::req_item_type)
//   response  out        rsp_strobe, one cycle          rsp_item (cbs_pkg::rsp_item_type)
//   config    in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A word is accepted every cycle while busy is low; its response passes through the s1
// registers and then the response register.
// The byte memory is read on acceptance and written back in the cycle after; a following
// word that reads the same byte takes the written value from a bypass register.
// After reset a clearing pass zeroes the memory, one byte per cycle, and busy stays
// high until it finishes.
// The receiver cannot stall, so no back-pressure reaches the request side.
`timescale 1ns / 1ps
`include "counted_bitmap_store_core_macros.svh"

module counted_bitmap_store_core #(
   parameter int MAX_BITS = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  cbs_pkg::req_item_type  req_item,
   output logic                   rsp_strobe,
   output cbs_pkg::rsp_item_type  rsp_item,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
   localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int CMP_W = ($clog2(MAX_BITS + 1) > 15) ? $clog2(MAX_BITS + 1) : 15;
   localparam int CW = cbs_pkg::COUNT_W;

   cbs_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ptr_ff, clr_ptr_in;
   logic               clearing;

   logic [CW-1:0]      bits_in_use_ff, bits_in_use_in;
   logic [CW-1:0]      count_ff, count_in;

   logic               req_fire;
   logic [CMP_W-1:0]   size_lim;
   logic [CMP_W-1:0]   bits_ext;
   logic [CMP_W-1:0]   idx_ext;
   logic [CMP_W-1:0]   byte_bits_ext;
   logic [11:0]        byte_no;
   logic [ADDR_W+11:0] byte_no_ext;
   logic [ADDR_W-1:0]  acc_addr;
   logic               acc_err;

   logic               s1_valid_ff;
   logic [2:0]         s1_op_ff;
   logic               s1_err_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic [2:0]         s1_bit_ff;
   logic [7:0]         s1_wbyte_ff;
   logic               s1_fwd_ff, s1_fwd_in;
   logic [7:0]         s1_fwd_data_ff;

   logic [7:0]         ram_rdata;
   logic [7:0]         cur_byte;
   logic [7:0]         bit_mask;
   logic               bit_now;
   logic [7:0]         new_byte;
   logic               s1_we;
   logic               res_bit;
   logic [7:0]         res_byte;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [7:0]         ram_wdata;

   logic                  rsp_valid_ff;
   cbs_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic               csr_write;
   logic               rsp_err;

   // Clearing pass and run state.
   always_comb begin
      state_in   = state_ff;
      clr_ptr_in = clr_ptr_ff;
      case (state_ff)
         cbs_pkg::ST_CLEAR: begin
            clr_ptr_in = clr_ptr_ff + ADDR_W'(1);
            if (clr_ptr_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = cbs_pkg::ST_RUN;
            end
         end
         cbs_pkg::ST_RUN: begin
            state_in = cbs_pkg::ST_RUN;
         end
         default: begin
            state_in = cbs_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      case (state_ff)
         cbs_pkg::ST_CLEAR: clearing = 1'b1;
         cbs_pkg::ST_RUN:   clearing = 1'b0;
         default:           clearing = 1'b1;
      endcase
   end

   assign busy     = clearing;
   assign req_fire = start && !busy;

   // Acceptance: range check and byte address.
   assign bits_ext      = CMP_W'(bits_in_use_ff);
   assign size_lim      = (bits_ext < CMP_W'(MAX_BITS)) ? bits_ext : CMP_W'(MAX_BITS);
   assign idx_ext       = CMP_W'(req_item.index);
   assign byte_bits_ext = CMP_W'({req_item.index, 3'b000});

   always_comb begin
      acc_err = 1'b0;
      byte_no = req_item.index;
      case (req_item.opcode)
         cbs_pkg::OP_SET_BIT, cbs_pkg::OP_CLEAR_BIT, cbs_pkg::OP_TEST_BIT: begin
            acc_err = (idx_ext >= size_lim);
            byte_no = {3'd0, req_item.index[11:3]};
         end
         cbs_pkg::OP_WRITE_BYTE, cbs_pkg::OP_READ_BYTE: begin
            acc_err = (byte_bits_ext >= size_lim);
         end
         default: begin
            acc_err = 1'b0;
         end
      endcase
   end

   assign byte_no_ext = {{ADDR_W{1'b0}}, byte_no};
   assign acc_addr    = byte_no_ext[ADDR_W-1:0];
   assign s1_fwd_in   = s1_we && (s1_addr_ff == acc_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff       <= req_item.opcode;
         s1_err_ff      <= acc_err;
         s1_addr_ff     <= acc_addr;
         s1_bit_ff      <= req_item.index[2:0];
         s1_wbyte_ff    <= req_item.write_byte;
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_data_ff <= new_byte;
      end
   end

   // Modify and write back.
   assign cur_byte = s1_fwd_ff ? s1_fwd_data_ff : ram_rdata;
   assign bit_mask = 8'd1 << s1_bit_ff;
   assign bit_now  = |(cur_byte & bit_mask);

   always_comb begin
      new_byte = cur_byte;
      s1_we    = 1'b0;
      count_in = count_ff;
      res_bit  = 1'b0;
      res_byte = 8'd0;
      if (s1_valid_ff && !s1_err_ff) begin
         case (s1_op_ff)
            cbs_pkg::OP_SET_BIT: begin
               if (!bit_now) begin
                  s1_we    = 1'b1;
                  new_byte = cur_byte | bit_mask;
                  count_in = count_ff + CW'(1);
               end
            end
            cbs_pkg::OP_CLEAR_BIT: begin
               if (bit_now) begin
                  s1_we    = 1'b1;
                  new_byte = cur_byte & ~bit_mask;
                  count_in = count_ff - CW'(1);
               end
            end
            cbs_pkg::OP_TEST_BIT: begin
               res_bit = bit_now;
            end
            cbs_pkg::OP_WRITE_BYTE: begin
               s1_we    = 1'b1;
               new_byte = s1_wbyte_ff;
               count_in = count_ff - CW'(cbs_pkg::pop8(cur_byte))
                          + CW'(cbs_pkg::pop8(s1_wbyte_ff));
            end
            cbs_pkg::OP_READ_BYTE: begin
               res_byte = cur_byte;
            end
            default: begin
               s1_we = 1'b0;
            end
         endcase
      end
   end

   assign ram_we    = clearing || s1_we;
   assign ram_waddr = clearing ? clr_ptr_ff : s1_addr_ff;
   assign ram_wdata = clearing ? 8'd0 : new_byte;

   cbs_byte_ram #(
      .DEPTH  (STORE_BYTES),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_fire),
      .rd_addr (acc_addr),
      .rd_data (ram_rdata)
   );

   // Response register.
   always_comb begin
      rsp_item_in.bit_value   = res_bit;
      rsp_item_in.read_byte   = res_byte;
      rsp_item_in.ones_count  = count_in;
      rsp_item_in.range_error = s1_err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;
   assign rsp_err    = rsp_strobe && rsp_item.range_error;

   // Register port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[2] == cbs_pkg::CSR_IDX_BITS_IN_USE);
   assign bits_in_use_in = csr_write ? pwdata[CW-1:0] : bits_in_use_ff;
   assign prdata = (paddr[2] == cbs_pkg::CSR_IDX_BITS_IN_USE)
                   ? {{(32 - CW){1'b0}}, bits_in_use_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= cbs_pkg::ST_CLEAR;
         clr_ptr_ff     <= '0;
         bits_in_use_ff <= cbs_pkg::BITS_IN_USE_RESET;
         count_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         clr_ptr_ff     <= clr_ptr_in;
         bits_in_use_ff <= bits_in_use_in;
         count_ff       <= count_in;
      end
   end

   `CBS_ASSERT_NOW(a_no_rsp_while_clearing, clock, reset, clearing, !rsp_valid_ff)
   `CBS_ASSERT_NEXT(a_accept_reaches_s1, clock, reset, req_fire, s1_valid_ff)
   `CBS_ASSERT_NEXT(a_s1_gives_rsp, clock, reset, s1_valid_ff, rsp_strobe)
   `CBS_ASSERT_NOW(a_error_keeps_count, clock, reset, rsp_err, count_ff == $past(count_ff))
   `CBS_ASSERT_NOW(a_error_no_data, clock, reset, rsp_err, !rsp_item.bit_value && !(|rsp_item.read_byte))

endmodule
